>>> hw/rtl/sfr_pkg.sv
// sfr_pkg: shared types, constants and byte helpers for the stream find/replace block
// used by every module under hw/rtl; depends on nothing else

package sfr_pkg;

   localparam int unsigned MAX_PATTERN     = 8;
   localparam int unsigned MAX_REPLACEMENT = 8;
   localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_CMP   = 3'd1,
      S_FALL  = 3'd2,
      S_REPL  = 3'd3,
      S_FLUSH = 3'd4,
      S_NL    = 3'd5
   } scan_state_type;

   // one byte offered by the scanner to the output stage, plus end-of-item marker
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       fin;
   } emit_type;

   function automatic logic [7:0] byte_sel(input logic [63:0] word, input logic [2:0] idx);
      byte_sel = word[{idx, 3'b000} +: 8];
   endfunction

   function automatic logic [3:0] clamp_plen(input logic [3:0] raw);
      logic [3:0] n;
      n = raw;
      if (n == 4'd0) n = 4'd1;
      if (32'(n) > MAX_PATTERN) n = 4'(MAX_PATTERN);
      clamp_plen = n;
   endfunction

   function automatic logic [3:0] clamp_rlen(input logic [3:0] raw);
      logic [3:0] n;
      n = raw;
      if (32'(n) > MAX_REPLACEMENT) n = 4'(MAX_REPLACEMENT);
      clamp_rlen = n;
   endfunction

endpackage

>>> hw/rtl/stream_find_replace_core.sv
// stream_find_replace_core: top level of the streaming find/replace block
// depends on sfr_pkg, sfr_fallback_table, sfr_scanner, sfr_out_stage
//
// Usage:
//   req_* carries one text byte per beat (req_end_of_stream marks the final byte).
//   rsp_* returns the rewritten stream, zero to nine beats per input byte;
//   rsp_last_of_run is set on the final beat caused by one input byte.
//   csr_* writes pattern bytes/length and replacement bytes/length; write only while idle.
//   Each input byte runs through a small sequencer sharing one byte comparator:
//   a plain byte is accepted and then compared; every fallback step adds a compare
//   plus the release of each dropped byte, and a full match adds the emission of
//   each replacement byte. A newline is accepted, then the held bytes are flushed
//   (the flush step is taken even when nothing is held) and the newline is sent; end of
//   stream appends the same flush and newline after the compare. req_ready is low
//   while a byte is in work.
//   The first rsp beat of a byte goes from the sequencer into the hold slot and then the
//   output register, since each beat waits in the hold slot until the next one (or the end
//   of the byte) is known.
//   A write to the pattern rebuilds the fallback table, one compare per cycle;
//   req_ready stays low meanwhile.
//   Reset clears the held match, the table and the output stage; pattern length is 1.
//   When the receiver stalls, beats back up into the hold slot and the sequencer waits.

module stream_find_replace_core import sfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0] pattern_ff, pattern_in;
   logic [3:0]  plen_ff, plen_in;
   logic [63:0] rep_ff, rep_in;
   logic [3:0]  rlen_ff, rlen_in;
   logic        pat_wr;
   logic [3:0]  plen_eff;
   logic [3:0]  rlen_eff;
   logic [2:0]  tbl_addr;
   logic [2:0]  tbl_data;
   logic        tbl_busy;
   logic        push_ok;
   emit_type    emit;
   reg_index_type csr_reg;

   assign csr_reg  = reg_index_type'(csr_index);
   assign pat_wr   = csr_we && (csr_reg == REG_PATTERN_BYTES || csr_reg == REG_PATTERN_LENGTH);
   assign plen_eff = clamp_plen(plen_ff);
   assign rlen_eff = clamp_rlen(rlen_ff);

   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      rep_in     = rep_ff;
      rlen_in    = rlen_ff;
      if (csr_we) begin
         case (csr_reg)
            REG_PATTERN_BYTES:      pattern_in = csr_wdata;
            REG_PATTERN_LENGTH:     plen_in    = csr_wdata[3:0];
            REG_REPLACEMENT_BYTES:  rep_in     = csr_wdata;
            REG_REPLACEMENT_LENGTH: rlen_in    = csr_wdata[3:0];
            default: begin
               pattern_in = pattern_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= 64'd0;
         plen_ff    <= 4'd1;
         rep_ff     <= 64'd0;
         rlen_ff    <= 4'd0;
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
         rep_ff     <= rep_in;
         rlen_ff    <= rlen_in;
      end
   end

   sfr_fallback_table u_table (
      .clock   (clock),
      .reset   (reset),
      .start   (pat_wr),
      .pattern (pattern_ff),
      .plen    (plen_eff),
      .rd_addr (tbl_addr),
      .rd_data (tbl_data),
      .busy    (tbl_busy)
   );

   sfr_scanner u_scanner (
      .clock             (clock),
      .reset             (reset),
      .pat_wr            (pat_wr),
      .pattern           (pattern_ff),
      .plen              (plen_eff),
      .replacement       (rep_ff),
      .rlen              (rlen_eff),
      .tbl_busy          (tbl_busy),
      .tbl_addr          (tbl_addr),
      .tbl_data          (tbl_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .push_ok           (push_ok),
      .emit              (emit)
   );

   sfr_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .emit            (emit),
      .push_ok         (push_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> hw/rtl/sfr_fallback_table.sv
// sfr_fallback_table: prefix fallback table and its iterative rebuild engine
// one byte compare per cycle; depends on sfr_pkg

module sfr_fallback_table import sfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] pattern,
   input  logic [3:0]  plen,
   input  logic [2:0]  rd_addr,
   output logic [2:0]  rd_data,
   output logic        busy
);

   logic [2:0] tbl_ff [8];
   logic [2:0] tbl_in [8];
   logic       busy_ff, busy_in;
   logic [3:0] i_ff, i_in;
   logic [2:0] k_ff, k_in;
   logic [7:0] byte_i, byte_k;
   logic       bytes_eq;
   logic [2:0] tbl_addr;
   logic [2:0] tbl_rd;

   assign byte_i   = byte_sel(pattern, i_ff[2:0]);
   assign byte_k   = byte_sel(pattern, k_ff);
   assign bytes_eq = (byte_i == byte_k);
   // the rebuild owns the read port while it runs
   assign tbl_addr = busy_ff ? (k_ff - 3'd1) : rd_addr;
   assign tbl_rd   = tbl_ff[tbl_addr];
   assign rd_data  = tbl_rd;
   assign busy     = busy_ff;

   always_comb begin
      tbl_in  = tbl_ff;
      busy_in = busy_ff;
      i_in    = i_ff;
      k_in    = k_ff;
      if (start) begin
         for (int e = 0; e < 8; e++) tbl_in[e] = 3'd0;
         busy_in = 1'b1;
         i_in    = 4'd1;
         k_in    = 3'd0;
      end else if (busy_ff) begin
         if (i_ff >= plen) begin
            busy_in = 1'b0;
         end else if (!bytes_eq && k_ff != 3'd0) begin
            k_in = tbl_rd;
         end else if (bytes_eq) begin
            k_in = k_ff + 3'd1;
            tbl_in[i_ff[2:0]] = k_ff + 3'd1;
            i_in = i_ff + 4'd1;
         end else begin
            tbl_in[i_ff[2:0]] = 3'd0;
            i_in = i_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < 8; e++) tbl_ff[e] <= 3'd0;
         busy_ff <= 1'b0;
         i_ff    <= 4'd1;
         k_ff    <= 3'd0;
      end else begin
         tbl_ff  <= tbl_in;
         busy_ff <= busy_in;
         i_ff    <= i_in;
         k_ff    <= k_in;
      end
   end

   // a border of a one-byte prefix is always empty
   assert property (@(posedge clock) disable iff (reset) tbl_ff[0] == 3'd0)
      else $error("fallback entry zero not empty");

   // the running border stays shorter than the prefix being scanned
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && (i_ff < plen) |-> ({1'b0, k_ff} < i_ff))
      else $error("fallback border not shorter than prefix");

endmodule

>>> hw/rtl/sfr_scanner.sv
// sfr_scanner: per-byte match sequencer, one pattern compare or one emitted byte per cycle
// while push_ok is high; depends on sfr_pkg; reads the fallback table, feeds sfr_out_stage

module sfr_scanner import sfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pat_wr,
   input  logic [63:0] pattern,
   input  logic [3:0]  plen,
   input  logic [63:0] replacement,
   input  logic [3:0]  rlen,
   input  logic        tbl_busy,
   output logic [2:0]  tbl_addr,
   input  logic [2:0]  tbl_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   input  logic        push_ok,
   output emit_type    emit
);

   scan_state_type state_ff, state_in;
   logic [7:0] c_ff, c_in;
   logic       last_ff, last_in;
   logic [2:0] q_ff, q_in;
   logic [3:0] j_ff, j_in;
   logic [2:0] f_ff, f_in;
   logic       fin_pend_ff, fin_pend_in;

   logic [7:0]     cmp_byte, pat_j, rep_j;
   logic           eq;
   logic [3:0]     q_plus;
   logic [3:0]     span;
   logic           accept;
   scan_state_type tail_state;

   assign cmp_byte   = byte_sel(pattern, q_ff);
   assign eq         = (cmp_byte == c_ff);
   assign pat_j      = byte_sel(pattern, j_ff[2:0]);
   assign rep_j      = byte_sel(replacement, j_ff[2:0]);
   assign q_plus     = {1'b0, q_ff} + 4'd1;
   assign span       = {1'b0, q_ff} - {1'b0, f_ff};
   assign tbl_addr   = q_ff - 3'd1;
   assign accept     = req_valid && req_ready;
   assign tail_state = last_ff ? S_FLUSH : S_IDLE;

   // outputs
   always_comb begin
      emit      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            emit.fin  = fin_pend_ff;
            req_ready = !tbl_busy && (!fin_pend_ff || push_ok);
         end
         S_CMP: begin
            emit.valid = (q_ff == 3'd0) && !eq;
            emit.data  = c_ff;
         end
         S_FALL: begin
            emit.valid = 1'b1;
            emit.data  = pat_j;
         end
         S_REPL: begin
            emit.valid = 1'b1;
            emit.data  = rep_j;
         end
         S_FLUSH: begin
            emit.valid = (q_ff != 3'd0);
            emit.data  = pat_j;
         end
         S_NL: begin
            emit.valid = 1'b1;
            emit.data  = NEWLINE_BYTE;
         end
         default: begin
            emit = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      c_in        = c_ff;
      last_in     = last_ff;
      q_in        = q_ff;
      j_in        = j_ff;
      f_in        = f_ff;
      fin_pend_in = fin_pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (fin_pend_ff && push_ok) fin_pend_in = 1'b0;
            if (accept) begin
               c_in    = req_in_byte;
               last_in = req_end_of_stream;
               j_in    = 4'd0;
               if (req_in_byte == NEWLINE_BYTE) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_CMP;
                  if ({1'b0, q_ff} >= plen) q_in = 3'd0;
               end
            end
         end
         S_CMP: begin
            if (q_ff != 3'd0 && !eq) begin
               // mismatch: release the bytes that the fallback drops
               f_in     = tbl_data;
               j_in     = 4'd0;
               state_in = S_FALL;
            end else if (eq) begin
               j_in = 4'd0;
               if (q_plus == plen) begin
                  q_in = 3'd0;
                  if (rlen != 4'd0) begin
                     state_in = S_REPL;
                  end else begin
                     state_in    = tail_state;
                     fin_pend_in = !last_ff;
                  end
               end else begin
                  q_in        = q_plus[2:0];
                  state_in    = tail_state;
                  fin_pend_in = !last_ff;
               end
            end else if (push_ok) begin
               j_in        = 4'd0;
               state_in    = tail_state;
               fin_pend_in = !last_ff;
            end
         end
         S_FALL: begin
            if (push_ok) begin
               if (j_ff + 4'd1 == span) begin
                  q_in     = f_ff;
                  state_in = S_CMP;
               end else begin
                  j_in = j_ff + 4'd1;
               end
            end
         end
         S_REPL: begin
            if (push_ok) begin
               if (j_ff + 4'd1 == rlen) begin
                  j_in        = 4'd0;
                  state_in    = tail_state;
                  fin_pend_in = !last_ff;
               end else begin
                  j_in = j_ff + 4'd1;
               end
            end
         end
         S_FLUSH: begin
            if (q_ff == 3'd0) begin
               state_in = S_NL;
            end else if (push_ok) begin
               if (j_ff + 4'd1 == {1'b0, q_ff}) begin
                  q_in     = 3'd0;
                  state_in = S_NL;
               end else begin
                  j_in = j_ff + 4'd1;
               end
            end
         end
         S_NL: begin
            if (push_ok) begin
               state_in    = S_IDLE;
               fin_pend_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a new pattern drops any held partial match
      if (pat_wr) q_in = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         q_ff        <= 3'd0;
         fin_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         q_ff        <= q_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      last_ff <= last_in;
      j_ff    <= j_in;
      f_ff    <= f_in;
   end

   // held partial match is always shorter than the pattern
   assert property (@(posedge clock) disable iff (reset) {1'b0, q_ff} < plen)
      else $error("held match not shorter than pattern");

   // a fallback always shortens the held match
   assert property (@(posedge clock) disable iff (reset) state_ff == S_FALL |-> f_ff < q_ff)
      else $error("fallback does not shorten match");

endmodule

>>> hw/rtl/sfr_out_stage.sv
// sfr_out_stage: one-beat hold slot plus output register; tags the final beat of each byte
// depends on sfr_pkg; driven by sfr_scanner

module sfr_out_stage import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  emit_type   emit,
   output logic       push_ok,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push_ok  = !pend_valid_ff || out_free;

   // a beat waits in the hold slot until we know whether another follows it
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (push_ok) begin
         if (emit.valid) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_byte_ff;
               rsp_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_byte_in  = emit.data;
         end else if (emit.fin && pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = pend_byte_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // closing a byte's run moves the held beat out tagged as last and empties the slot
   assert property (@(posedge clock) disable iff (reset)
      emit.fin && !emit.valid && pend_valid_ff && push_ok
      |=> rsp_valid_ff && rsp_last_ff && !pend_valid_ff)
      else $error("run close did not deliver last beat");

endmodule
